@@ design/mqe_pkg.sv @@
// ----------------------------------------------------------------------------
// mqe_pkg
// Shared types, constants and helpers for the mail body QP line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mqe_pkg;

   localparam int unsigned DATA_W     = 8;
   localparam int unsigned POS_W      = 7;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned HELD_DEPTH = 4;
   localparam int unsigned HELD_IDX_W = 2;
   localparam int unsigned LINE_LIMIT = 75;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // register map (byte addresses)
   localparam logic [CSR_ADDR_W-1:0] REG_CONVERT_8BIT = 2'd0;

   // prefix phase codes: 1..4 = that many "From " bytes held
   localparam logic [PHASE_W-1:0] PH_START = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LAST  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_BODY  = 3'd5;

   localparam logic [DATA_W-1:0] CH_EQ    = 8'h3D;
   localparam logic [DATA_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
   localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
   localparam logic [DATA_W-1:0] CH_CASE  = 8'h20;
   localparam logic [DATA_W-1:0] CH_TOP   = 8'h7E;

   // lower-case "from", matched against byte | 0x20
   localparam logic [DATA_W-1:0] FROM_WORD [HELD_DEPTH] = '{8'h66, 8'h72, 8'h6F, 8'h6D};

   // first action after decoding an item
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_FLUSH,
      STEP_DOT,
      STEP_CHAR,
      STEP_ESC,
      STEP_BODY,
      STEP_CR
   } step_type;

   // output character source
   typedef enum logic [2:0] {
      SEL_HELD,
      SEL_DOT,
      SEL_EQ,
      SEL_HI,
      SEL_LO,
      SEL_BYTE,
      SEL_CR,
      SEL_LF
   } sel_type;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_PRE    = 14'b00000000000010,
      ST_FLUSH  = 14'b00000000000100,
      ST_DOT    = 14'b00000000001000,
      ST_BODY   = 14'b00000000010000,
      ST_SB_EQ  = 14'b00000000100000,
      ST_SB_CR  = 14'b00000001000000,
      ST_SB_LF  = 14'b00000010000000,
      ST_ESC_EQ = 14'b00000100000000,
      ST_ESC_HI = 14'b00001000000000,
      ST_ESC_LO = 14'b00010000000000,
      ST_CHAR   = 14'b00100000000000,
      ST_CR     = 14'b01000000000000,
      ST_LF     = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic    load;      // latch incoming item
      logic    pre;       // decode cycle: update prefix state
      logic    emit;      // load output register
      sel_type sel;
      logic    last;
      logic    line_end;  // LF closes the line
   } cmd_type;

   typedef struct packed {
      step_type          step;
      step_type          after_flush;
      logic              flush_done;
      logic              need_sb;
      logic              esc_body;
      logic              esc_held;
      logic              eol;
      logic              out_free;
      logic [POS_W-1:0]  line_pos;
   } status_type;

   function automatic logic [DATA_W-1:0] hex_char(input logic [3:0] nib);
      logic [DATA_W-1:0] wide;
      wide = {4'h0, nib};
      hex_char = (nib < 4'd10) ? (wide + 8'h30) : (wide + 8'h37);
   endfunction

endpackage

`default_nettype wire

@@ design/mail_body_qp_line_encoder.sv @@
// ----------------------------------------------------------------------------
// mail_body_qp_line_encoder
// Quoted-printable / dot-stuffing encoder for mail body lines.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one item per body byte (tdata), tuser[0] = byte present,
//    tlast = line end. A line end with no byte is legal and just closes the
//    line with CR LF.
//  - rsp_*: one encoded character per item on tdata; tlast marks the final
//    character caused by an input item. Items that produce nothing (a held
//    "From " prefix byte, or no byte and no line end) give no output.
//  - csr_*: one register at byte address 0, bit 0 = convert_8bit. Write it
//    only while the block is idle.
// Sequence: an item is accepted, then decoded, then gives its output characters,
//  0 to 9 of them, one per step, with a check step ahead of a QP body byte.
//  An escaped QP byte gives = and two hex digits, a soft break gives = CR LF
//  and a line end gives CR LF. The pace is set by the single-character output
//  register fed by the step sequencer.
// Stall: the sequencer holds while the output register is full and rsp_tready
//  is low; the next item is taken while the last character of the previous
//  one still waits in the output register.
// Reset: synchronous; clears mode, line position and prefix state.
// ----------------------------------------------------------------------------
`default_nettype none

module mail_body_qp_line_encoder (
   input  wire                               clock,
   input  wire                               reset,
   // input items
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [mqe_pkg::DATA_W-1:0]        req_tdata,   // [7:0] data_byte
   input  wire  [0:0]                        req_tuser,   // [0] has_byte
   input  wire                               req_tlast,   // end_of_line
   // result items
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [mqe_pkg::DATA_W-1:0]        rsp_tdata,   // [7:0] out_char
   output logic                              rsp_tlast,   // last_of_run
   // configuration
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [mqe_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [mqe_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mqe_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import mqe_pkg::*;

   logic       convert_ff, convert_in;
   logic       csr_write;
   cmd_type    cmd;
   status_type status;

   // ---- configuration register ----
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      convert_in = convert_ff;
      if (csr_write && (csr_paddr == REG_CONVERT_8BIT)) convert_in = csr_pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) convert_ff <= 1'b0;
      else       convert_ff <= convert_in;
   end

   assign csr_prdata = (csr_paddr == REG_CONVERT_8BIT) ? {{(CSR_DATA_W-1){1'b0}}, convert_ff}
                                                       : '0;

   // ---- sequencer and datapath ----
   mqe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mqe_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .convert_8bit (convert_ff),
      .data_byte    (req_tdata),
      .has_byte     (req_tuser[0]),
      .end_of_line  (req_tlast),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

   // ---- assertions ----
   // decode cycle always follows an accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready right after accepting an item");

   // an empty item (no byte, no line end) returns to idle after decode
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0] && !req_tlast) |=> ##1 req_tready)
      else $error("empty item did not return to idle");

   // soft breaks keep the line position within the limit
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      status.line_pos <= POS_W'(LINE_LIMIT))
      else $error("line position beyond line limit");

   // nothing is emitted into a full, stalled output register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !cmd.emit)
      else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

@@ design/mqe_ctrl.sv @@
// ----------------------------------------------------------------------------
// mqe_ctrl
// Sequencer: walks one item through flush, dot, escape, soft break, character and CRLF steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mqe_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire mqe_pkg::status_type status,
   output mqe_pkg::cmd_type         cmd
);
   import mqe_pkg::*;

   state_type state_ff, state_in;

   function automatic state_type step_state(input step_type s);
      case (s)
         STEP_FLUSH: step_state = ST_FLUSH;
         STEP_DOT:   step_state = ST_DOT;
         STEP_CHAR:  step_state = ST_CHAR;
         STEP_ESC:   step_state = ST_ESC_EQ;
         STEP_BODY:  step_state = ST_BODY;
         STEP_CR:    step_state = ST_CR;
         default:    step_state = ST_IDLE;
      endcase
   endfunction

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      logic emitting;
      emitting     = 1'b0;
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.pre      = 1'b0;
      cmd.sel      = SEL_BYTE;
      cmd.last     = 1'b0;
      cmd.line_end = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = ST_PRE;
         end
         ST_PRE: begin
            cmd.pre  = 1'b1;
            state_in = step_state(status.step);
         end
         ST_FLUSH: begin
            emitting = 1'b1;
            cmd.sel  = SEL_HELD;
            if (status.out_free)
               state_in = status.flush_done ? step_state(status.after_flush) : ST_FLUSH;
         end
         ST_DOT: begin
            emitting = 1'b1;
            cmd.sel  = SEL_DOT;
            if (status.out_free) state_in = ST_CHAR;
         end
         ST_BODY: begin
            if (status.need_sb)       state_in = ST_SB_EQ;
            else if (status.esc_body) state_in = ST_ESC_EQ;
            else                      state_in = ST_CHAR;
         end
         ST_SB_EQ: begin
            emitting = 1'b1;
            cmd.sel  = SEL_EQ;
            if (status.out_free) state_in = ST_SB_CR;
         end
         ST_SB_CR: begin
            emitting = 1'b1;
            cmd.sel  = SEL_CR;
            if (status.out_free) state_in = ST_SB_LF;
         end
         ST_SB_LF: begin
            emitting = 1'b1;
            cmd.sel  = SEL_LF;
            if (status.out_free) state_in = status.esc_body ? ST_ESC_EQ : ST_CHAR;
         end
         ST_ESC_EQ: begin
            emitting = 1'b1;
            cmd.sel  = SEL_EQ;
            if (status.out_free) state_in = ST_ESC_HI;
         end
         ST_ESC_HI: begin
            emitting = 1'b1;
            cmd.sel  = SEL_HI;
            if (status.out_free) state_in = ST_ESC_LO;
         end
         ST_ESC_LO: begin
            emitting = 1'b1;
            cmd.sel  = SEL_LO;
            cmd.last = !status.esc_held && !status.eol;
            if (status.out_free) begin
               if (status.esc_held) state_in = ST_FLUSH;
               else                 state_in = status.eol ? ST_CR : ST_IDLE;
            end
         end
         ST_CHAR: begin
            emitting = 1'b1;
            cmd.sel  = SEL_BYTE;
            cmd.last = !status.eol;
            if (status.out_free) state_in = status.eol ? ST_CR : ST_IDLE;
         end
         ST_CR: begin
            emitting = 1'b1;
            cmd.sel  = SEL_CR;
            if (status.out_free) state_in = ST_LF;
         end
         ST_LF: begin
            emitting     = 1'b1;
            cmd.sel      = SEL_LF;
            cmd.last     = 1'b1;
            cmd.line_end = 1'b1;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      cmd.emit = emitting && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

@@ design/mqe_dp.sv @@
// ----------------------------------------------------------------------------
// mqe_dp
// Datapath: item latch, prefix store, line position, decode and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqe_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          convert_8bit,
   input  wire  [mqe_pkg::DATA_W-1:0]   data_byte,
   input  wire                          has_byte,
   input  wire                          end_of_line,
   input  wire mqe_pkg::cmd_type        cmd,
   output mqe_pkg::status_type          status,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [mqe_pkg::DATA_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast
);
   import mqe_pkg::*;

   localparam logic [POS_W-1:0] LimitPlain = POS_W'(LINE_LIMIT);
   localparam logic [POS_W-1:0] LimitEsc   = POS_W'(LINE_LIMIT - 2);

   // item latch
   logic [DATA_W-1:0]     byte_ff, byte_in;
   logic                  has_ff, has_in;
   logic                  eol_ff, eol_in;

   // line state
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DATA_W-1:0]     held_ff [HELD_DEPTH];

   // per-item sequencing state
   logic [HELD_IDX_W-1:0] idx_ff, idx_in;
   logic [PHASE_W-1:0]    cnt_ff, cnt_in;
   logic                  esc_held_ff, esc_held_in;
   logic                  esc_add_ff, esc_add_in;
   logic                  flush_eol_ff, flush_eol_in;

   // output register
   logic                  valid_ff, valid_in;
   logic [DATA_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  match, in_prefix, is_dot;
   logic                  dec_hold, dec_from, dec_flush, dec_dot_plain, dec_dot_qp;
   logic [DATA_W-1:0]     esc_byte;
   logic                  esc_body;
   step_type              step;

   // ---- decode of the latched item against the line state ----
   assign in_prefix = (phase_ff != PH_START) && (phase_ff != PH_BODY);
   assign is_dot    = (byte_ff == CH_DOT);
   assign match     = (phase_ff == PH_LAST) ? (byte_ff == CH_SPACE)
                    : ((byte_ff | CH_CASE) == FROM_WORD[phase_ff[HELD_IDX_W-1:0]]);

   assign dec_hold      = has_ff && convert_8bit && match &&
                          (((phase_ff == PH_START) && !is_dot) ||
                           (in_prefix && (phase_ff != PH_LAST)));
   assign dec_from      = has_ff && convert_8bit && (phase_ff == PH_LAST) && match;
   assign dec_flush     = has_ff && in_prefix && (!convert_8bit || !match);
   assign dec_dot_plain = has_ff && !convert_8bit && (phase_ff == PH_START) && is_dot;
   assign dec_dot_qp    = has_ff && convert_8bit && (phase_ff == PH_START) && is_dot;

   always_comb begin
      if (!has_ff) begin
         if (!eol_ff)        step = STEP_NONE;
         else if (in_prefix) step = STEP_FLUSH;
         else                step = STEP_CR;
      end else if (dec_hold)                step = eol_ff ? STEP_FLUSH : STEP_NONE;
      else if (dec_flush)                   step = STEP_FLUSH;
      else if (dec_dot_plain)               step = STEP_DOT;
      else if (!convert_8bit)               step = STEP_CHAR;
      else if (dec_dot_qp || dec_from)      step = STEP_ESC;
      else                                  step = STEP_BODY;
   end

   // escape rule for a body byte; a space is escaped only when its own item ends the line
   assign esc_body = (byte_ff == CH_EQ) || (byte_ff < CH_SPACE) || (byte_ff > CH_TOP) ||
                     (eol_ff && (byte_ff == CH_SPACE));
   assign esc_byte = esc_held_ff ? held_ff[0] : byte_ff;

   assign status.step        = step;
   assign status.after_flush = flush_eol_ff ? STEP_CR
                             : ((convert_8bit && !esc_held_ff) ? STEP_BODY : STEP_CHAR);
   assign status.flush_done  = ({1'b0, idx_ff} == (cnt_ff - 3'd1));
   assign status.need_sb     = pos_ff >= (esc_body ? LimitEsc : LimitPlain);
   assign status.esc_body    = esc_body;
   assign status.esc_held    = esc_held_ff;
   assign status.eol         = eol_ff;
   assign status.out_free    = !valid_ff || rsp_tready;
   assign status.line_pos    = pos_ff;

   // ---- next-state logic ----
   always_comb begin
      byte_in      = byte_ff;
      has_in       = has_ff;
      eol_in       = eol_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      esc_held_in  = esc_held_ff;
      esc_add_in   = esc_add_ff;
      flush_eol_in = flush_eol_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      valid_in     = valid_ff && !rsp_tready;

      if (cmd.load) begin
         byte_in = data_byte;
         has_in  = has_byte;
         eol_in  = end_of_line;
      end

      if (cmd.pre) begin
         cnt_in       = dec_hold ? (phase_ff + 3'd1) : phase_ff;
         idx_in       = dec_from ? HELD_IDX_W'(1) : HELD_IDX_W'(0);
         esc_held_in  = dec_from;
         esc_add_in   = !(dec_from || dec_dot_qp);
         flush_eol_in = eol_ff && (dec_hold || (!has_ff && in_prefix));
         if (dec_hold)    phase_in = phase_ff + 3'd1;
         else if (has_ff) phase_in = PH_BODY;
         // first body byte of a QP line restarts the position count
         if (convert_8bit && has_ff && (phase_ff == PH_START) && !dec_hold)
            pos_in = dec_dot_qp ? POS_W'(1) : POS_W'(0);
      end

      if (cmd.emit) begin
         valid_in = 1'b1;
         last_in  = cmd.last;
         case (cmd.sel)
            SEL_HELD: begin
               char_in = held_ff[idx_ff];
               idx_in  = idx_ff + HELD_IDX_W'(1);
               // held bytes restart the line count in QP mode
               if (convert_8bit) pos_in = POS_W'(idx_ff) + POS_W'(1);
            end
            SEL_DOT: char_in = CH_DOT;
            SEL_EQ:  char_in = CH_EQ;
            SEL_HI:  char_in = hex_char(esc_byte[7:4]);
            SEL_LO: begin
               char_in = hex_char(esc_byte[3:0]);
               if (esc_add_ff) pos_in = pos_ff + POS_W'(3);
            end
            SEL_BYTE: begin
               char_in = byte_ff;
               if (convert_8bit) pos_in = pos_ff + POS_W'(1);
            end
            SEL_CR:  char_in = CH_CR;
            SEL_LF: begin
               char_in = CH_LF;
               pos_in  = '0;
               if (cmd.line_end) phase_in = PH_START;
            end
            default: char_in = char_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      has_ff       <= has_in;
      eol_ff       <= eol_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      esc_held_ff  <= esc_held_in;
      esc_add_ff   <= esc_add_in;
      flush_eol_ff <= flush_eol_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

   // prefix store, written only while a "From " match is in progress
   always_ff @(posedge clock) begin
      if (cmd.pre && dec_hold) held_ff[phase_ff[HELD_IDX_W-1:0]] <= byte_ff;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

@@ bench/mail_body_qp_line_encoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mail_body_qp_line_encoder_test
// Self-checking bench for the mail body line encoder. Body bytes go in one per
// item on the req stream, and every encoded character that comes out on the
// rsp stream is compared with a predicted stream. The prediction covers
// quoted-printable escapes, soft breaks, the "From " guard, the leading-dot
// rules and plain dot-stuffing. Both stream ends idle at random and the
// receiver also stalls for one long stretch. The mode register is switched
// between runs of traffic.
// ----------------------------------------------------------------------------

import mqe_pkg::*;

typedef struct packed {
   logic [DATA_W-1:0] out_char;
   logic              last_of_run;
} qp_char_type;

// Predicts the encoded character stream and holds it until it is checked.
class qp_char_board;
   qp_char_type       expected_chars[$];
   logic [DATA_W-1:0] run_chars[$];
   bit                qp_mode;
   logic [PHASE_W-1:0] prefix_phase;
   logic [DATA_W-1:0] held_bytes[HELD_DEPTH];
   logic [POS_W-1:0]  line_pos;
   int                mismatches;

   function new();
      qp_mode      = 1'b0;
      prefix_phase = PH_START;
      line_pos     = '0;
      mismatches   = 0;
   endfunction

   function void set_mode(bit mode);
      qp_mode = mode;
   endfunction

   function int pending();
      return expected_chars.size();
   endfunction

   function logic [DATA_W-1:0] hex_digit(logic [3:0] nib);
      if (nib < 4'd10)
         return {4'h0, nib} + 8'h30;
      return {4'h0, nib} + 8'h37;
   endfunction

   function void emit_escape(logic [DATA_W-1:0] b);
      run_chars.push_back(CH_EQ);
      run_chars.push_back(hex_digit(b[7:4]));
      run_chars.push_back(hex_digit(b[3:0]));
   endfunction

   function bit prefix_matches(logic [DATA_W-1:0] b, int idx);
      if (idx >= 4)
         return b == CH_SPACE;
      return (b | CH_CASE) == FROM_WORD[idx];
   endfunction

   // one body byte in QP mode, with a soft break ahead of it if needed
   function void encode_byte(logic [DATA_W-1:0] b, bit at_line_end);
      bit esc;
      int thr;
      esc = (b == CH_EQ) || (b < CH_SPACE) || (b > CH_TOP) ||
            (at_line_end && b == CH_SPACE);
      thr = LINE_LIMIT - (esc ? 2 : 0);
      if (int'(line_pos) >= thr) begin
         run_chars.push_back(CH_EQ);
         run_chars.push_back(CH_CR);
         run_chars.push_back(CH_LF);
         line_pos = '0;
      end
      if (esc) begin
         emit_escape(b);
         line_pos = line_pos + 7'd3;
      end else begin
         run_chars.push_back(b);
         line_pos = line_pos + 7'd1;
      end
   endfunction

   function void flush_prefix(bit plain);
      int n;
      n = prefix_phase;
      if (n < 1 || n > 4)
         return;
      if (!plain)
         line_pos = '0;
      for (int i = 0; i < n; i++) begin
         if (plain)
            run_chars.push_back(held_bytes[i]);
         else
            encode_byte(held_bytes[i], 1'b0);
      end
      prefix_phase = PH_BODY;
   endfunction

   // called for every accepted input item
   function void accept_item(logic [DATA_W-1:0] b, bit has_byte, bit end_of_line);
      int ph;
      qp_char_type c;
      run_chars.delete();
      if (prefix_phase > PH_BODY)
         prefix_phase = PH_BODY;
      if (has_byte) begin
         if (!qp_mode) begin
            if (prefix_phase >= 1 && prefix_phase <= PH_LAST)
               flush_prefix(1'b1);
            if (prefix_phase == PH_START && b == CH_DOT)
               run_chars.push_back(CH_DOT);
            run_chars.push_back(b);
            prefix_phase = PH_BODY;
         end else if (prefix_phase == PH_START) begin
            if (b == CH_DOT) begin
               emit_escape(b);
               line_pos     = 7'd1;
               prefix_phase = PH_BODY;
            end else if (prefix_matches(b, 0)) begin
               held_bytes[0] = b;
               prefix_phase  = 3'd1;
            end else begin
               line_pos     = '0;
               prefix_phase = PH_BODY;
               encode_byte(b, end_of_line);
            end
         end else if (prefix_phase <= PH_LAST) begin
            ph = prefix_phase;
            if (prefix_matches(b, ph)) begin
               if (ph < 4) begin
                  held_bytes[ph] = b;
                  prefix_phase   = prefix_phase + 3'd1;
               end else begin
                  emit_escape(held_bytes[0]);
                  run_chars.push_back(held_bytes[1]);
                  run_chars.push_back(held_bytes[2]);
                  run_chars.push_back(held_bytes[3]);
                  run_chars.push_back(b);
                  line_pos     = 7'd5;
                  prefix_phase = PH_BODY;
               end
            end else begin
               flush_prefix(1'b0);
               encode_byte(b, end_of_line);
            end
         end else begin
            encode_byte(b, end_of_line);
         end
      end
      if (end_of_line) begin
         if (prefix_phase >= 1 && prefix_phase <= PH_LAST)
            flush_prefix(!qp_mode);
         run_chars.push_back(CH_CR);
         run_chars.push_back(CH_LF);
         prefix_phase = PH_START;
         line_pos     = '0;
      end
      foreach (run_chars[i]) begin
         c.out_char    = run_chars[i];
         c.last_of_run = (i == run_chars.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   function void check_char(logic [DATA_W-1:0] out_char, logic last_of_run);
      qp_char_type e;
      if (expected_chars.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected char %02h last %0b", out_char, last_of_run);
         return;
      end
      e = expected_chars.pop_front();
      if (e.out_char !== out_char || e.last_of_run !== last_of_run) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected char %02h last %0b, got char %02h last %0b",
                     e.out_char, e.last_of_run, out_char, last_of_run);
      end
   endfunction
endclass

module mail_body_qp_line_encoder_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SEG_ITEMS    = 40;
   localparam int DRAIN_CYCLES = 12;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata;   // [7:0] data_byte
   logic [0:0]             req_tuser;   // [0] has_byte
   logic                   req_tlast;   // end_of_line
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [DATA_W-1:0]      rsp_tdata;   // [7:0] out_char
   logic                   rsp_tlast;   // last_of_run
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   qp_char_board board = new();

   int send_idle_pct;   // chance in 100 that the sender skips a cycle
   int recv_idle_pct;   // chance in 100 that the receiver drops tready
   int items_sent;      // items that carry a byte or a line end
   int cycle_count;
   int hold_left;
   bit hold_request;    // set by stimulus, picked up by the receiver

   mail_body_qp_line_encoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mail_body_qp_line_encoder_test NOT OK");
         $finish;
      end
   end

   // Receiver: checks every accepted char. Values are sampled at the edge,
   // before any update made at that edge. A hold request turns into a long
   // stretch of tready low while the sender keeps going.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_char(rsp_tdata, rsp_tlast);
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // One item on the req stream; returns at the edge where it was taken.
   // The prediction is made right there, well ahead of its first char.
   task automatic send_item(input logic [DATA_W-1:0] data_byte, input bit has_byte,
                            input bit end_of_line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tuser  <= has_byte;
      req_tlast  <= end_of_line;
      do @(posedge clock); while (!req_tready);
      board.accept_item(data_byte, has_byte, end_of_line);
      if (has_byte || end_of_line)
         items_sent++;
   endtask

   // Let everything drain, then give an item that makes no chars time to
   // leave the decoder before the mode changes.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit qp);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_CONVERT_8BIT;
      csr_pwdata  <= {{(CSR_DATA_W-1){1'b0}}, qp};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_mode(qp);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly printable, with a fair share of the bytes that need attention
   function automatic logic [DATA_W-1:0] body_byte();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return DATA_W'($urandom_range(8'h21, 8'h7E));
      if (r < 72)
         return CH_SPACE;
      if (r < 78)
         return CH_EQ;
      if (r < 84)
         return CH_DOT;
      return DATA_W'($urandom_range(255));
   endfunction

   // A well-formed line with random content: "From " openers in mixed case,
   // broken prefixes, leading dots, empty lines, short and long bodies.
   task automatic send_random_line();
      logic [DATA_W-1:0] line_bytes[$];
      int kind;
      int len;
      int held_count;
      bit eol_on_byte;
      kind = $urandom_range(99);
      if (kind < 20) begin
         for (int i = 0; i < 4; i++)
            line_bytes.push_back(FROM_WORD[i] ^ ($urandom_range(1) ? CH_CASE : 8'h00));
         line_bytes.push_back(CH_SPACE);
      end else if (kind < 32) begin
         held_count = $urandom_range(1, 4);
         for (int i = 0; i < held_count; i++)
            line_bytes.push_back(FROM_WORD[i] ^ ($urandom_range(1) ? CH_CASE : 8'h00));
         line_bytes.push_back(body_byte());
      end else if (kind < 44) begin
         line_bytes.push_back(CH_DOT);
      end
      if (kind >= 44 && kind < 50)
         len = 0;
      else if ($urandom_range(7) == 0)
         len = $urandom_range(60, 110);
      else
         len = $urandom_range(0, 20);
      for (int i = 0; i < len; i++)
         line_bytes.push_back(body_byte());
      eol_on_byte = (line_bytes.size() > 0) && $urandom_range(1);
      foreach (line_bytes[i]) begin
         // occasional empty item: no byte, no line end
         if ($urandom_range(19) == 0)
            send_item(DATA_W'($urandom_range(255)), 1'b0, 1'b0);
         send_item(line_bytes[i], 1'b1, eol_on_byte && (i == line_bytes.size() - 1));
      end
      if (!eol_on_byte)
         send_item(DATA_W'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin
      bit seg_mode[6];
      seg_mode     = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= '0;
      req_tlast    <= 1'b0;
      rsp_tready   <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      cycle_count  = 0;
      hold_left    = 0;
      hold_request = 1'b0;
      items_sent   = 0;
      send_idle_pct = 16;
      recv_idle_pct = 51;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain mode out of reset: leading dot is doubled
      send_item(CH_DOT, 1'b1, 1'b0);
      send_item("a", 1'b1, 1'b1);
      wait_idle();
      write_mode(1'b1);

      // "From " ending the line, mixed case: first byte escaped, space as is
      send_item("F", 1'b1, 1'b0);
      send_item("r", 1'b1, 1'b0);
      send_item("o", 1'b1, 1'b0);
      send_item("M", 1'b1, 1'b0);
      send_item(CH_SPACE, 1'b1, 1'b1);
      // prefix broken on its last byte: held bytes re-encoded, then the byte
      send_item("f", 1'b1, 1'b0);
      send_item("R", 1'b1, 1'b0);
      send_item("o", 1'b1, 1'b0);
      send_item("m", 1'b1, 1'b0);
      send_item("x", 1'b1, 1'b1);
      // leading dot, then a space that ends the line with its own item
      send_item(CH_DOT, 1'b1, 1'b0);
      send_item(CH_SPACE, 1'b1, 1'b1);
      // field extremes, CR as data, and a trailing space before a byteless end
      send_item(CH_EQ, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(CH_CR, 1'b1, 1'b0);
      send_item(CH_SPACE, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      // nothing at all, then a line end while a prefix is held
      send_item(8'h00, 1'b0, 1'b0);
      send_item("F", 1'b1, 1'b0);
      send_item("r", 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // held prefix across a switch to plain mode
      send_item("F", 1'b1, 1'b0);
      send_item("r", 1'b1, 1'b0);
      wait_idle();
      write_mode(1'b0);
      send_item("x", 1'b1, 1'b1);

      // random traffic; idle profile changes every two runs
      for (int seg = 0; seg < 6; seg++) begin
         wait_idle();
         write_mode(seg_mode[seg]);
         if (seg == 2) begin
            send_idle_pct = 51;
            recv_idle_pct = 16;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_request  = 1'b1;
         end
         items_sent = 0;
         while (items_sent < SEG_ITEMS)
            send_random_line();
      end

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.pending() != 0)
         $display("%0d expected chars never arrived", board.pending());
      if (board.mismatches == 0 && board.pending() == 0)
         $display("mail_body_qp_line_encoder_test OK");
      else
         $display("mail_body_qp_line_encoder_test NOT OK");
      $finish;
   end

endmodule
